@@ rtl/sptl_pkg.sv @@
// sorted point table lookup: shared types and constants
// no dependencies
package sptl_pkg;

  localparam int unsigned DefaultDepth = 1024;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_SPARE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] payload;
  } item_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         position;
    logic signed [31:0] found_value;
  } item_out_t;

  // one table record as stored in memory
  typedef struct packed {
    logic [31:0] east;
    logic [31:0] north;
    logic [31:0] value;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_LOAD,   // read entry j
    S_SORT_KEY,    // latch entry j, read entry i-1
    S_SORT_CMP,    // compare entry i-1 against key
    S_SORT_NEXT,   // after a shift, read the new entry i-1
    S_SORT_PUT,    // write key record at i, next j
    S_SRCH_RD,     // read mid
    S_SRCH_CMP,    // compare mid
    S_FIN_RD,      // read lo-1
    S_FIN_CMP      // final compare and respond
  } state_e;

  // signed order via sign flip, east then north
  function automatic logic [63:0] make_key(logic [31:0] ex, logic [31:0] ny);
    make_key = {ex ^ 32'h8000_0000, ny ^ 32'h8000_0000};
  endfunction

endpackage

@@ rtl/sptl_ram.sv @@
// sorted point table lookup: generic single-port ram, registered read
// depends on nothing
module sptl_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/sorted_point_table_lookup_unit.sv @@
// sorted point table lookup: top level with sort and search sequencer
// depends on sptl_pkg and sptl_ram
//
// channel | direction | handshake       | payload
// command | in        | start_i, busy_o | item_i  (cmd, key_x, key_y, payload)
// result  | out       | done_o strobe   | result_o (status, position, found_value)
//
// append, clear and unused codes answer straight from idle through the registered done_q
// a lookup on a sorted table is a binary search on the single memory port:
// one probe read and one compare per step
// the first lookup after appends runs an insertion sort first on the same port:
// each record is read and latched, larger records below it shift up, then it is written
// reset returns to idle, clears count and done and sets the sorted flag; the memory needs no clearing
// results cannot be stalled: done_o is high for one cycle
module sorted_point_table_lookup_unit #(
  parameter int unsigned TableDepth = sptl_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  sptl_pkg::item_in_t  item_i,
  output logic                done_o,
  output sptl_pkg::item_out_t result_o
);
  import sptl_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);

  state_e      state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic        sorted_q, sorted_d;
  item_in_t    item_q, item_d;
  // sort cursors
  logic [CW-1:0] j_q, j_d, i_q, i_d;
  rec_t        key_rec_q, key_rec_d;
  // search bounds
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic        done_q, done_d;
  item_out_t   res_q, res_d;

  logic        we;
  logic [AW-1:0] addr;
  rec_t        wdata, rdata;
  logic [CW-1:0] mid;
  logic [63:0] target;

  sptl_ram #(.Width($bits(rec_t)), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign target = make_key(item_q.key_x, item_q.key_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      sorted_q <= 1'b1;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sorted_q <= sorted_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    j_q       <= j_d;
    i_q       <= i_d;
    key_rec_q <= key_rec_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    sorted_d  = sorted_q;
    item_d    = item_q;
    j_d       = j_q;
    i_d       = i_q;
    key_rec_d = key_rec_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    done_d    = 1'b0;
    res_d     = res_q;
    we        = 1'b0;
    addr      = '0;
    wdata     = key_rec_q;

    unique case (state_q)
      S_IDLE: begin
        // the strobe cycle still counts as busy
        if (start_i && !done_q) begin
          item_d = item_i;
          res_d  = '{status: ST_OK, position: '0, found_value: '0};
          case (cmd_e'(item_i.cmd))
            CMD_APPEND: begin
              done_d = 1'b1;
              if (count_q >= CW'(TableDepth)) begin
                res_d.status = ST_FULL;
              end else begin
                we       = 1'b1;
                addr     = count_q[AW-1:0];
                wdata    = '{east: item_i.key_x, north: item_i.key_y,
                             value: item_i.payload};
                count_d  = count_q + 1'b1;
                sorted_d = 1'b0;
              end
            end
            CMD_LOOKUP: begin
              lo_d = '0;
              hi_d = count_q;
              j_d  = CW'(1);
              state_d = sorted_q ? S_SRCH_RD : S_SORT_LOAD;
            end
            CMD_CLEAR: begin
              done_d   = 1'b1;
              count_d  = '0;
              sorted_d = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_SORT_LOAD: begin
        if (j_q >= count_q) begin
          sorted_d = 1'b1;
          state_d  = S_SRCH_RD;
        end else begin
          addr    = j_q[AW-1:0];
          i_d     = j_q;
          state_d = S_SORT_KEY;
        end
      end
      S_SORT_KEY: begin
        key_rec_d = rdata;
        addr      = AW'(i_q - 1'b1);
        state_d   = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (make_key(rdata.east, rdata.north) > make_key(key_rec_q.east, key_rec_q.north)) begin
          // shift record up one slot
          we    = 1'b1;
          addr  = i_q[AW-1:0];
          wdata = rdata;
          i_d   = i_q - 1'b1;
          state_d = (i_q == CW'(1)) ? S_SORT_PUT : S_SORT_NEXT;
        end else begin
          state_d = S_SORT_PUT;
        end
      end
      S_SORT_NEXT: begin
        addr    = AW'(i_q - 1'b1);
        state_d = S_SORT_CMP;
      end
      S_SORT_PUT: begin
        we      = 1'b1;
        addr    = i_q[AW-1:0];
        wdata   = key_rec_q;
        j_d     = j_q + 1'b1;
        state_d = S_SORT_LOAD;
      end
      S_SRCH_RD: begin
        if (lo_q < hi_q) begin
          addr    = mid[AW-1:0];
          state_d = S_SRCH_CMP;
        end else if (lo_q == '0) begin
          res_d.status = ST_NOT_FOUND;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          addr    = AW'(lo_q - 1'b1);
          state_d = S_FIN_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (make_key(rdata.east, rdata.north) <= target) lo_d = mid + 1'b1;
        else hi_d = mid;
        state_d = S_SRCH_RD;
      end
      S_FIN_RD: begin
        addr    = AW'(lo_q - 1'b1);
        state_d = S_FIN_CMP;
      end
      S_FIN_CMP: begin
        done_d = 1'b1;
        if (make_key(rdata.east, rdata.north) == target) begin
          res_d.position    = 10'(lo_q - 1'b1);
          res_d.found_value = rdata.value;
        end else begin
          res_d.status = ST_NOT_FOUND;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o   = (state_q != S_IDLE) || done_q;
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TableDepth)) else $error("count above depth");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result strobe");
  a_sorted_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_RD) |-> sorted_q) else $error("search on unsorted table");
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_RD) |-> (lo_q <= hi_q)) else $error("search bounds crossed");
`endif
endmodule

@@ bench/tb_top.sv @@
// testbench for the sorted point table lookup unit: directed, random and full table
// checks every result against an in-bench predictor or typed row; depends on sptl_pkg
`timescale 1ns / 1ps

module tb_top;
  import sptl_pkg::*;

  localparam int unsigned Depth = sptl_pkg::DefaultDepth;
  localparam logic signed [31:0] MinW = 32'sh8000_0000;
  localparam logic signed [31:0] MaxW = 32'sh7fff_ffff;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  item_in_t  item_i;
  logic      done_o;
  item_out_t result_o;

  sorted_point_table_lookup_unit #(.TableDepth(Depth)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // model of the table: load order until sorted, sorted order afterwards
  logic signed [31:0] tbl_x [Depth];
  logic signed [31:0] tbl_y [Depth];
  logic signed [31:0] tbl_v [Depth];
  int unsigned        tbl_count;
  bit                 tbl_sorted;

  item_out_t   pending_results[$];
  int unsigned error_count;
  bit          quiet_sender;

  // directed rows; typed rows carry their expected result
  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] p;
    bit                 typed;
    item_out_t          want;
  } row_t;
  row_t directed_rows[$];

  function automatic bit key_above(logic signed [31:0] ax, logic signed [31:0] ay,
                                   logic signed [31:0] bx, logic signed [31:0] by);
    return (ax > bx) || (ax == bx && ay > by);
  endfunction

  // stable insertion sort, east first then north
  function automatic void sort_points();
    logic signed [31:0] kx, ky, kv;
    int i;
    for (int j = 1; j < tbl_count; j++) begin
      kx = tbl_x[j];
      ky = tbl_y[j];
      kv = tbl_v[j];
      i = j;
      while (i > 0 && key_above(tbl_x[i-1], tbl_y[i-1], kx, ky)) begin
        tbl_x[i] = tbl_x[i-1];
        tbl_y[i] = tbl_y[i-1];
        tbl_v[i] = tbl_v[i-1];
        i--;
      end
      tbl_x[i] = kx;
      tbl_y[i] = ky;
      tbl_v[i] = kv;
    end
    tbl_sorted = 1'b1;
  endfunction

  function automatic item_out_t predict_point_op(item_in_t it);
    item_out_t r;
    int unsigned lo, hi, mid;
    r = '{status: ST_OK, position: '0, found_value: '0};
    case (cmd_e'(it.cmd))
      CMD_APPEND: begin
        if (tbl_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          tbl_x[tbl_count] = it.key_x;
          tbl_y[tbl_count] = it.key_y;
          tbl_v[tbl_count] = it.payload;
          tbl_count++;
          tbl_sorted = 1'b0;
        end
      end
      CMD_LOOKUP: begin
        if (!tbl_sorted) sort_points();
        lo = 0;
        hi = tbl_count;
        // lo ends as the number of records at or below the key
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (!key_above(tbl_x[mid], tbl_y[mid], it.key_x, it.key_y)) lo = mid + 1;
          else hi = mid;
        end
        if (lo > 0 && tbl_x[lo-1] == it.key_x && tbl_y[lo-1] == it.key_y) begin
          r.position    = 10'(lo - 1);
          r.found_value = tbl_v[lo-1];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: begin
        tbl_count  = 0;
        tbl_sorted = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
    error_count++;
  endtask

  // result side: the receiver cannot stall, so every strobe is checked here
  always @(posedge clk_i) begin
    item_out_t w;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("mismatch at %0t: result with nothing outstanding", $realtime);
        error_count++;
      end else begin
        w = pending_results.pop_front();
        if (result_o.status !== w.status)
          report_mismatch("status", 32'(result_o.status), 32'(w.status));
        if (result_o.position !== w.position)
          report_mismatch("position", 32'(result_o.position), 32'(w.position));
        if (result_o.found_value !== w.found_value)
          report_mismatch("found_value", result_o.found_value, w.found_value);
      end
    end
  end

  // hand one item over; the expectation is queued at the accepting edge
  task automatic issue_item(item_in_t it, bit typed = 1'b0, item_out_t want = '0);
    item_out_t p;
    if (!quiet_sender && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    p = predict_point_op(it);
    pending_results.push_back(typed ? want : p);
  endtask

  task automatic issue_op(cmd_e c, logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] p);
    item_in_t it;
    it = '{cmd: c, key_x: x, key_y: y, payload: p};
    issue_item(it);
  endtask

  task automatic add_row(cmd_e c, logic signed [31:0] x, logic signed [31:0] y,
                         logic signed [31:0] p, bit typed = 1'b0,
                         status_e s = ST_OK, int unsigned pos = 0,
                         logic signed [31:0] v = 0);
    row_t r;
    r.cmd   = c;
    r.x     = x;
    r.y     = y;
    r.p     = p;
    r.typed = typed;
    r.want  = '{status: s, position: 10'(pos), found_value: v};
    directed_rows.push_back(r);
  endtask

  // random coordinate drawn from a small pool so that duplicates and hits are common
  function automatic logic signed [31:0] pick_coord(int unsigned pool_base);
    case ($urandom_range(0, 9))
      0:       return MinW;
      1:       return MaxW;
      2:       return $urandom;
      default: return pool_base + $urandom_range(0, 5) - 3;
    endcase
  endfunction

  initial begin
    item_in_t           it;
    logic signed [31:0] hx, hy;
    int unsigned        sent, group_len, base, pick;
    start_i      = 1'b0;
    item_i       = '0;
    rst_ni       = 1'b0;
    error_count  = 0;
    quiet_sender = 1'b0;
    tbl_count    = 0;
    tbl_sorted   = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: extremes, duplicates, empty table, key below every record
    add_row(CMD_LOOKUP, 0, 0, 0, 1, ST_NOT_FOUND);
    add_row(CMD_NONE, MaxW, MinW, -1, 1, ST_OK);
    add_row(CMD_CLEAR, 0, 0, 0, 1, ST_OK);
    add_row(CMD_APPEND, MaxW, MaxW, MinW, 1, ST_OK);
    add_row(CMD_APPEND, MinW, MinW, MaxW, 1, ST_OK);
    add_row(CMD_APPEND, 0, 0, 5, 1, ST_OK);
    add_row(CMD_APPEND, 0, 0, 7, 1, ST_OK);
    add_row(CMD_APPEND, 0, -1, 9, 1, ST_OK);
    add_row(CMD_APPEND, -1, MaxW, 11, 1, ST_OK);
    add_row(CMD_LOOKUP, MinW, MinW, 0, 1, ST_OK, 0, MaxW);
    add_row(CMD_LOOKUP, MaxW, MaxW, 0, 1, ST_OK, 5, MinW);
    add_row(CMD_LOOKUP, 0, 0, 0, 1, ST_OK, 4, 7);
    add_row(CMD_LOOKUP, MinW, MinW + 1, 0, 1, ST_NOT_FOUND);
    add_row(CMD_LOOKUP, 0, 1, 0, 1, ST_NOT_FOUND);
    add_row(CMD_APPEND, 5, 5, -3);
    add_row(CMD_LOOKUP, 5, 5, 0);
    add_row(CMD_LOOKUP, 0, -1, 0);
    add_row(CMD_CLEAR, 1, 2, 3, 1, ST_OK);
    add_row(CMD_LOOKUP, 0, 0, 0, 1, ST_NOT_FOUND);
    add_row(CMD_APPEND, 10, 10, 1, 1, ST_OK);
    add_row(CMD_LOOKUP, -5, -5, 0, 1, ST_NOT_FOUND);
    add_row(CMD_LOOKUP, 10, 10, 0, 1, ST_OK, 0, 1);
    add_row(CMD_NONE, -7, 7, 77, 1, ST_OK);
    add_row(CMD_CLEAR, 0, 0, 0, 1, ST_OK);
    foreach (directed_rows[i]) begin
      it = '{cmd: directed_rows[i].cmd, key_x: directed_rows[i].x,
             key_y: directed_rows[i].y, payload: directed_rows[i].p};
      issue_item(it, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part: load groups of records, then look them up, usually cleared in between
    sent = 0;
    while (sent < 420) begin
      base = $urandom;
      if ($urandom_range(0, 3) != 0) begin
        issue_op(CMD_CLEAR, $urandom, $urandom, $urandom);
        sent++;
      end
      group_len = $urandom_range(1, 24);
      repeat (group_len) begin
        issue_op(CMD_APPEND, pick_coord(base), pick_coord(base), $urandom);
        sent++;
      end
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, 9);
        if (pick < 6 && tbl_count > 0) begin
          hx = tbl_x[$urandom_range(0, tbl_count - 1)];
          hy = tbl_y[$urandom_range(0, tbl_count - 1)];
          if (pick < 4) hy = tbl_y[0];
          if (pick < 4) hx = tbl_x[0];
          issue_op(CMD_LOOKUP, hx, hy, $urandom);
        end else if (pick == 9) begin
          // unused code and the odd extra append interleaved with lookups
          issue_op($urandom_range(0, 1) ? CMD_NONE : CMD_APPEND,
                   pick_coord(base), pick_coord(base), $urandom);
        end else begin
          issue_op(CMD_LOOKUP, pick_coord(base), pick_coord(base), $urandom);
        end
        sent++;
      end
    end

    // full table: ascending load keeps the sort cheap, then overflow appends
    issue_op(CMD_CLEAR, 0, 0, 0);
    for (int k = 0; k < Depth; k++)
      issue_op(CMD_APPEND, k * 4096 - 32'sd2000000, k % 3, $urandom);
    repeat (3) issue_op(CMD_APPEND, $urandom, $urandom, $urandom);
    issue_op(CMD_LOOKUP, -32'sd2000000, 0, 0);
    issue_op(CMD_LOOKUP, (Depth - 1) * 4096 - 32'sd2000000, (Depth - 1) % 3, 0);
    issue_op(CMD_LOOKUP, 512 * 4096 - 32'sd2000000, 512 % 3, 0);
    issue_op(CMD_LOOKUP, 12, 1, 0);
    issue_op(CMD_APPEND, 1, 1, 1);
    issue_op(CMD_CLEAR, 0, 0, 0);

    // closing stretch with no sender gaps
    quiet_sender = 1'b1;
    repeat (6) begin
      base = $urandom;
      repeat ($urandom_range(2, 10))
        issue_op(CMD_APPEND, pick_coord(base), pick_coord(base), $urandom);
      repeat (5) begin
        if (tbl_count > 0 && $urandom_range(0, 1)) begin
          pick = $urandom_range(0, tbl_count - 1);
          issue_op(CMD_LOOKUP, tbl_x[pick], tbl_y[pick], 0);
        end else begin
          issue_op(CMD_LOOKUP, pick_coord(base), pick_coord(base), 0);
        end
      end
      issue_op(CMD_CLEAR, 0, 0, 0);
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
